>>> design/pidc_pkg.sv
// Shared types and constants for the PID controller with deadband and clamp.
// Holds the register map, the configuration record and the control records
// that pass between the sequencer and the datapath. No dependencies.
package pidc_pkg;

	localparam int ADDR_W    = 5;
	localparam int DIV_STEPS = 32;

	// Register indexes, addressed at 4*index
	localparam logic [2:0] REG_GAIN_P       = 3'd0;
	localparam logic [2:0] REG_GAIN_I       = 3'd1;
	localparam logic [2:0] REG_GAIN_D       = 3'd2;
	localparam logic [2:0] REG_TIME_STEP    = 3'd3;
	localparam logic [2:0] REG_DEAD_BAND    = 3'd4;
	localparam logic [2:0] REG_LIMIT_HIGH   = 3'd5;
	localparam logic [2:0] REG_LIMIT_LOW    = 3'd6;
	localparam logic [2:0] REG_CLAMP_ENABLE = 3'd7;

	localparam logic signed [15:0] RST_GAIN_P     = 16'sd256;
	localparam logic signed [15:0] RST_GAIN_I     = 16'sd0;
	localparam logic signed [15:0] RST_GAIN_D     = 16'sd0;
	localparam logic [15:0]        RST_TIME_STEP  = 16'd655;
	localparam logic [14:0]        RST_DEAD_BAND  = 15'd0;
	localparam logic signed [15:0] RST_LIMIT_HIGH = 16'sh7FFF;
	localparam logic signed [15:0] RST_LIMIT_LOW  = 16'sh8000;
	localparam logic               RST_CLAMP_EN   = 1'b1;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	typedef struct packed {
		logic signed [15:0] gain_p;
		logic signed [15:0] gain_i;
		logic signed [15:0] gain_d;
		logic [15:0]        time_step;
		logic [14:0]        dead_band;
		logic signed [15:0] limit_high;
		logic signed [15:0] limit_low;
		logic               clamp_enable;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_E,
		ST_INTEG,
		ST_ACC_P,
		ST_ACC_I,
		ST_DIV,
		ST_MUL_D,
		ST_ACC_D,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		MS_E_TS,
		MS_GP,
		MS_GI,
		MS_GD
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD_SH8,
		ACC_ADD,
		ACC_ADD_SH8
	} acc_op_t;

	typedef struct packed {
		logic     load;
		logic     clear_int;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     integ_en;
		acc_op_t  acc_op;
		logic     div_step;
		logic     out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_sts_t;

endpackage

>>> design/pidc_if.sv
// Valid/ready channel interfaces for sample requests and result requests.
// No dependencies.
interface pidc_sample_if;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic signed [15:0] error_in;

	modport source (output valid, output cmd, output error_in, input ready);
	modport sink   (input valid, input cmd, input error_in, output ready);
endinterface

interface pidc_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] drive_out;
	logic               clamped;

	modport source (output valid, output drive_out, output clamped, input ready);
	modport sink   (input valid, input drive_out, input clamped, output ready);
endinterface

>>> design/pidc_regs.sv
// APB-style configuration register file for the PID controller.
// Depends on pidc_pkg for the register map and cfg_t.
module pidc_regs
	import pidc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p       <= RST_GAIN_P;
			cfg_q.gain_i       <= RST_GAIN_I;
			cfg_q.gain_d       <= RST_GAIN_D;
			cfg_q.time_step    <= RST_TIME_STEP;
			cfg_q.dead_band    <= RST_DEAD_BAND;
			cfg_q.limit_high   <= RST_LIMIT_HIGH;
			cfg_q.limit_low    <= RST_LIMIT_LOW;
			cfg_q.clamp_enable <= RST_CLAMP_EN;
		end else if (wr_en) begin
			case (idx)
				REG_GAIN_P:       cfg_q.gain_p       <= $signed(pwdata[15:0]);
				REG_GAIN_I:       cfg_q.gain_i       <= $signed(pwdata[15:0]);
				REG_GAIN_D:       cfg_q.gain_d       <= $signed(pwdata[15:0]);
				REG_TIME_STEP:    cfg_q.time_step    <= pwdata[15:0];
				REG_DEAD_BAND:    cfg_q.dead_band    <= pwdata[14:0];
				REG_LIMIT_HIGH:   cfg_q.limit_high   <= $signed(pwdata[15:0]);
				REG_LIMIT_LOW:    cfg_q.limit_low    <= $signed(pwdata[15:0]);
				REG_CLAMP_ENABLE: cfg_q.clamp_enable <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Signed registers read back sign-extended
	always_comb begin
		case (idx)
			REG_GAIN_P:       prdata = {{16{cfg_q.gain_p[15]}}, cfg_q.gain_p};
			REG_GAIN_I:       prdata = {{16{cfg_q.gain_i[15]}}, cfg_q.gain_i};
			REG_GAIN_D:       prdata = {{16{cfg_q.gain_d[15]}}, cfg_q.gain_d};
			REG_TIME_STEP:    prdata = {16'd0, cfg_q.time_step};
			REG_DEAD_BAND:    prdata = {17'd0, cfg_q.dead_band};
			REG_LIMIT_HIGH:   prdata = {{16{cfg_q.limit_high[15]}}, cfg_q.limit_high};
			REG_LIMIT_LOW:    prdata = {{16{cfg_q.limit_low[15]}}, cfg_q.limit_low};
			REG_CLAMP_ENABLE: prdata = {31'd0, cfg_q.clamp_enable};
			default:          prdata = 32'd0;
		endcase
	end

endmodule

>>> design/pidc_ctrl.sv
// Sequencer for the PID controller: walks one sample through the shared
// multiplier, the integral update and the serial divider.
// Depends on pidc_pkg for state_t and the command/status records.
module pidc_ctrl
	import pidc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      sample_valid,
	input  logic      sample_cmd,
	input  dp_sts_t   sts,
	output logic      sample_ready,
	output ctrl_cmd_t cmd
);

	localparam int CNT_W = $clog2(DIV_STEPS);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cnt_d        = '0;
		sample_ready = 1'b0;
		cmd          = '{load: 1'b0, clear_int: 1'b0, mul_en: 1'b0, mul_sel: MS_E_TS,
			integ_en: 1'b0, acc_op: ACC_HOLD, div_step: 1'b0, out_load: 1'b0};
		case (state_q)
			ST_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid) begin
					if (sample_cmd == CMD_CLEAR) begin
						cmd.clear_int = 1'b1;
					end else begin
						cmd.load = 1'b1;
						state_d  = ST_MUL_E;
					end
				end
			end
			ST_MUL_E: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_E_TS;
				state_d     = ST_INTEG;
			end
			ST_INTEG: begin
				cmd.integ_en = 1'b1;
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MS_GP;
				state_d      = ST_ACC_P;
			end
			ST_ACC_P: begin
				cmd.acc_op  = ACC_LOAD_SH8;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_GI;
				state_d     = ST_ACC_I;
			end
			ST_ACC_I: begin
				cmd.acc_op = ACC_ADD;
				state_d    = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_MUL_D;
				end
			end
			ST_MUL_D: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_GD;
				state_d     = ST_ACC_D;
			end
			ST_ACC_D: begin
				cmd.acc_op = ACC_ADD_SH8;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				// hold until the result register is free
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> design/pidc_datapath.sv
// Datapath of the PID controller: state registers, shared 17x33 multiplier,
// 60-bit accumulator, restoring divider and the clamp/result register.
// Depends on pidc_pkg for cfg_t and the command/status records.
module pidc_datapath
	import pidc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  ctrl_cmd_t          cmd,
	input  logic signed [15:0] sample_error,
	input  logic               out_ready,
	output dp_sts_t            sts,
	output logic               out_valid,
	output logic signed [15:0] drive_out,
	output logic               clamped
);

	localparam logic signed [43:0] Y_MAX = 44'sd32767;
	localparam logic signed [43:0] Y_MIN = -44'sd32768;

	// state with defined reset
	logic signed [31:0] integ_q;
	logic signed [15:0] prev_q;
	logic               out_valid_q;

	// per-sample working registers
	logic signed [15:0] e_q;
	logic               outside_q;
	logic               dneg_q;
	logic [31:0]        dq_q;
	logic [15:0]        rem_q;
	logic signed [49:0] prod_q;
	logic signed [59:0] acc_q;
	logic signed [15:0] drive_q;
	logic               clamped_q;

	logic signed [16:0] e_ext, db_ext, diff;
	logic [15:0]        diff_mag;
	logic               outside;
	logic signed [16:0] opa;
	logic signed [32:0] opb;
	logic signed [32:0] q_signed;
	logic signed [49:0] prod_d;
	logic signed [33:0] step34, sum34;
	logic signed [31:0] integ_d;
	logic signed [59:0] prod_ext, prod_sh8;
	logic [15:0]        divisor;
	logic [16:0]        rem_sh, rem_sub;
	logic signed [43:0] y, lh, ll, v;
	logic               lim;

	assign e_ext    = {sample_error[15], sample_error};
	assign db_ext   = {2'b00, cfg.dead_band};
	assign outside  = (e_ext > db_ext) || (e_ext < -db_ext);
	assign diff     = e_ext - {prev_q[15], prev_q};
	assign diff_mag = diff[16] ? 16'(-diff) : diff[15:0];

	assign q_signed = dneg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});

	always_comb begin
		case (cmd.mul_sel)
			MS_E_TS: begin
				opa = {e_q[15], e_q};
				opb = $signed({17'd0, cfg.time_step});
			end
			MS_GP: begin
				opa = {cfg.gain_p[15], cfg.gain_p};
				opb = {{17{e_q[15]}}, e_q};
			end
			MS_GI: begin
				opa = {cfg.gain_i[15], cfg.gain_i};
				opb = {integ_q[31], integ_q};
			end
			MS_GD: begin
				opa = {cfg.gain_d[15], cfg.gain_d};
				opb = q_signed;
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end
	assign prod_d = opa * opb;

	// integral step: floor shift of e*dt by 8, then saturate to 32 bits
	assign step34 = prod_q[41:8];
	assign sum34  = {{2{integ_q[31]}}, integ_q} + step34;
	always_comb begin
		if (sum34[33:31] == 3'b000 || sum34[33:31] == 3'b111) begin
			integ_d = sum34[31:0];
		end else if (sum34[33]) begin
			integ_d = 32'sh80000000;
		end else begin
			integ_d = 32'sh7FFFFFFF;
		end
	end

	assign prod_ext = {{10{prod_q[49]}}, prod_q};
	assign prod_sh8 = {prod_ext[51:0], 8'd0};

	// restoring division, one quotient bit a step
	assign divisor = (cfg.time_step == 16'd0) ? 16'd1 : cfg.time_step;
	assign rem_sh  = {rem_q, dq_q[31]};
	assign rem_sub = rem_sh - {1'b0, divisor};

	// output: floor shift by 16, optional clamp, then 16-bit saturation
	assign y  = acc_q[59:16];
	assign lh = {{28{cfg.limit_high[15]}}, cfg.limit_high};
	assign ll = {{28{cfg.limit_low[15]}}, cfg.limit_low};
	always_comb begin
		v   = y;
		lim = 1'b0;
		if (cfg.clamp_enable) begin
			if (v > lh) begin
				v   = lh;
				lim = 1'b1;
			end
			if (v < ll) begin
				v   = ll;
				lim = 1'b1;
			end
		end
		if (v > Y_MAX) begin
			v   = Y_MAX;
			lim = 1'b1;
		end
		if (v < Y_MIN) begin
			v   = Y_MIN;
			lim = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q     <= '0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_int) begin
				integ_q <= '0;
			end else if (cmd.integ_en && outside_q) begin
				integ_q <= integ_d;
			end
			if (cmd.load) begin
				prev_q <= sample_error;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			e_q       <= sample_error;
			outside_q <= outside;
			dneg_q    <= diff[16];
			dq_q      <= {diff_mag, 16'd0};
			rem_q     <= '0;
		end else if (cmd.div_step) begin
			if (!rem_sub[16]) begin
				rem_q <= rem_sub[15:0];
				dq_q  <= {dq_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh[15:0];
				dq_q  <= {dq_q[30:0], 1'b0};
			end
		end
		if (cmd.mul_en) begin
			prod_q <= prod_d;
		end
		case (cmd.acc_op)
			ACC_LOAD_SH8: acc_q <= prod_sh8;
			ACC_ADD:      acc_q <= acc_q + prod_ext;
			ACC_ADD_SH8:  acc_q <= acc_q + prod_sh8;
			default: ;
		endcase
		if (cmd.out_load) begin
			drive_q   <= v[15:0];
			clamped_q <= lim;
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign drive_out    = drive_q;
	assign clamped      = clamped_q;

endmodule

>>> design/pid_controller_deadband_sat_top.sv
// PID controller with integral deadband and output clamp: top level.
// Depends on pidc_pkg, pidc_if, pidc_regs, pidc_ctrl and pidc_datapath.
//
// Usage:
//   The sample channel takes one request per item: cmd selects a sample
//   (error_in, signed Q8.8) or a clear of the integral. The result channel
//   delivers drive_out (signed Q8.8) and clamped for each sample; a clear
//   gives no result and is absorbed in the cycle it is accepted.
//   A sample goes from acceptance to the result register through e*dt,
//   the integral update beside the P product, the P term beside the I
//   product, the I add, the restoring divider for (de << 16) / dt, the
//   D product and its add, then the clamp. One 17x33 multiplier serves all
//   four products. A new request is accepted in the cycle after the result
//   is loaded, so a new sample is taken only once the last one is through.
//   The result register parts the two channels: a stalled receiver holds the
//   result while the next sample is processed, and the block stalls only
//   when a second result is ready before the first has been taken.
//   Reset (arst_n low, asynchronous) loads the register defaults, zeroes the
//   integral and the previous error, and drops any pending result.
//   Configuration goes over the APB-style port, register i at byte 4*i;
//   write it only while no sample is in flight.
module pid_controller_deadband_sat_top
	import pidc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	pidc_sample_if.sink       sample,
	pidc_result_if.source     result
);

	cfg_t      cfg;
	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	// configuration registers
	pidc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer: accepts requests in idle and steps the datapath
	pidc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample.valid),
		.sample_cmd   (sample.cmd),
		.sts          (sts),
		.sample_ready (sample.ready),
		.cmd          (cmd)
	);

	// arithmetic, controller state and the result register
	pidc_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.sample_error (sample.error_in),
		.out_ready    (result.ready),
		.sts          (sts),
		.out_valid    (result.valid),
		.drive_out    (result.drive_out),
		.clamped      (result.clamped)
	);

endmodule

>>> design/pidc_checker.sv
// Port-level checker for the PID controller top level, bound to it below.
// Depends only on the top level's ports.
module pidc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_valid,
	input logic        s_ready,
	input logic        s_cmd,
	input logic        r_valid,
	input logic        r_ready,
	input logic [15:0] r_drive,
	input logic        r_clamped
);

	// a stalled result holds its value
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid && $stable(r_drive) && $stable(r_clamped))
		else $error("result changed while stalled");

	// a sample request keeps the block busy in the next cycle
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_valid && s_ready && !s_cmd |=> !s_ready)
		else $error("sample accepted while previous sample in flight");

	// no result can appear right after a request, sample or clear
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_valid && s_ready |=> !$rose(r_valid))
		else $error("result appeared one cycle after a request");

	// a new result is loaded only while the sample side is busy
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(r_valid) |-> $past(!s_ready))
		else $error("result rose while sample side was idle");

endmodule

bind pid_controller_deadband_sat_top pidc_checker u_pidc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_valid   (sample.valid),
	.s_ready   (sample.ready),
	.s_cmd     (sample.cmd),
	.r_valid   (result.valid),
	.r_ready   (result.ready),
	.r_drive   (result.drive_out),
	.r_clamped (result.clamped)
);
